// ===== rtl/core/tfn_pkg.sv =====
package tfn_pkg;

    // default coordinate width and output fraction bits
    localparam int COORD_WIDTH_DEF      = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 14;

    // control that travels beside the data through the front stages
    typedef struct packed {
        logic valid;
        logic deg;
    } ctrl_t;

endpackage

// ===== rtl/core/triangle_face_normal_unit.sv =====
// triangle face normal unit
// s_ channel: one triangle a beat, nine signed coordinates in s_tdata
// (a_x lowest, then a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z), zero-padded to bytes.
// m_ channel: one unit normal a beat, signed Q1.NORMAL_FRAC_BITS components in
// m_tdata (normal_x lowest, then normal_y, normal_z), degenerate flag in m_tuser.
// cfg channel: one-bit winding_flip, always ready; write only when the block is idle.
// a triangle is accepted whenever s_tready is high: one beat per cycle sustained while the output is not stalled.
// the division runs one quotient bit a stage and the square root one root bit a
// stage.
// the whole pipeline moves together: while the output beat waits on m_tready
// nothing advances and s_tready is low, so no beat is lost or repeated.
// reset (aresetn low, synchronous) empties the pipeline and clears winding_flip.
module triangle_face_normal_unit #(
    parameter int COORD_WIDTH      = tfn_pkg::COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF,
    localparam int NW = NORMAL_FRAC_BITS + 2,
    localparam int IW = ((9 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OW = ((3 * NW + 7) / 8) * 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [IW-1:0] s_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [OW-1:0] m_tdata,   // normal_x, normal_y, normal_z
    output logic          m_tuser,   // degenerate
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_data
);

    localparam int PW = 2 * (COORD_WIDTH + 1);
    localparam int SW = 2 * PW;
    localparam int LW = SW + 2;
    localparam int SB = NORMAL_FRAC_BITS + 2;
    localparam int UL = (2 * NORMAL_FRAC_BITS + 3) + SB;

    logic               en;
    logic               flip_reg;
    tfn_pkg::ctrl_t     c_cross, c_len;
    logic [PW-1:0]      mag [3];
    logic               neg_c [3];
    logic [SW-1:0]      sq [3];
    logic [LW-1:0]      len2;
    logic               neg_l [3];
    logic [SB-1:0]      root [3];
    logic               neg_u [3];
    tfn_pkg::ctrl_t     cd_reg [UL];
    logic               m_valid_reg;
    logic               m_deg_reg;
    logic [NW-1:0]      m_norm_reg [3];

    assign en        = !m_valid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // winding register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flip_reg <= 1'b0;
        end else if (cfg_valid) begin
            flip_reg <= cfg_data;
        end
    end

    tfn_cross #(.CW(COORD_WIDTH), .PW(PW)) u_cross (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s_tvalid), .flip(flip_reg),
        .coord_i(s_tdata[9*COORD_WIDTH-1:0]), .ctrl_o(c_cross), .mag_o(mag), .neg_o(neg_c)
    );

    tfn_len #(.MW(PW), .SW(SW), .LW(LW)) u_len (
        .aclk(aclk), .aresetn(aresetn), .en(en), .ctrl_i(c_cross), .mag_i(mag),
        .neg_i(neg_c), .ctrl_o(c_len), .sq_o(sq), .len2_o(len2), .neg_o(neg_l)
    );

    for (genvar i = 0; i < 3; i++) begin : g_unit
        tfn_unit #(.SW(SW), .LW(LW), .FB(NORMAL_FRAC_BITS), .SB(SB)) u_unit (
            .aclk(aclk), .en(en), .sq_i(sq[i]), .len2_i(len2), .neg_i(neg_l[i]),
            .root_o(root[i]), .neg_o(neg_u[i])
        );
    end

    // control delay line matching the units
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < UL; k++) cd_reg[k] <= '0;
        end else if (en) begin
            cd_reg[0] <= c_len;
            for (int k = 1; k < UL; k++) cd_reg[k] <= cd_reg[k-1];
        end
    end

    // output register: round, apply sign, zero for degenerate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= cd_reg[UL-1].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_deg_reg <= cd_reg[UL-1].deg;
            for (int i = 0; i < 3; i++) begin
                logic [SB-1:0] m_mag;
                m_mag = (root[i] + SB'(1)) >> 1;
                if (cd_reg[UL-1].deg) begin
                    m_norm_reg[i] <= '0;
                end else begin
                    m_norm_reg[i] <= neg_u[i] ? NW'(-m_mag) : NW'(m_mag);
                end
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_deg_reg;
    assign m_tdata  = OW'({m_norm_reg[2], m_norm_reg[1], m_norm_reg[0]});

endmodule

// ===== rtl/core/tfn_cross.sv =====
module tfn_cross #(
    parameter int CW = tfn_pkg::COORD_WIDTH_DEF,
    parameter int PW = 2 * (CW + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic                flip,
    input  logic [9*CW-1:0]     coord_i,
    output tfn_pkg::ctrl_t      ctrl_o,
    output logic [PW-1:0]       mag_o [3],
    output logic                neg_o [3]
);

    localparam int EW = CW + 1;

    logic signed [EW-1:0] e1_next [3];
    logic signed [EW-1:0] e2_next [3];
    logic signed [EW-1:0] e1_reg  [3];
    logic signed [EW-1:0] e2_reg  [3];
    logic signed [PW-1:0] p_reg   [3];
    logic signed [PW-1:0] q_reg   [3];
    logic signed [PW:0]   n_next  [3];
    logic [PW-1:0]        mag_reg [3];
    logic                 neg_reg [3];
    logic                 v1_reg, v2_reg;
    tfn_pkg::ctrl_t       ctrl_reg;

    // edge vectors, with optional swap of second and third vertex
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [CW-1:0] av, bv, cv, sb, sc;
            av = signed'(coord_i[i*CW +: CW]);
            bv = signed'(coord_i[(3+i)*CW +: CW]);
            cv = signed'(coord_i[(6+i)*CW +: CW]);
            sb = flip ? cv : bv;
            sc = flip ? bv : cv;
            e1_next[i] = EW'(sb) - EW'(av);
            e2_next[i] = EW'(sc) - EW'(av);
        end
    end

    // cross product differences
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_next[i] = (PW+1)'(p_reg[i]) - (PW+1)'(q_reg[i]);
        end
    end

    // control bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            ctrl_reg <= '0;
        end else if (en) begin
            v1_reg         <= in_valid;
            v2_reg         <= v1_reg;
            ctrl_reg.valid <= v2_reg;
            ctrl_reg.deg   <= (n_next[0] == '0) && (n_next[1] == '0) && (n_next[2] == '0);
        end
    end

    // edges, partial products, magnitudes
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                e1_reg[i]  <= e1_next[i];
                e2_reg[i]  <= e2_next[i];
                p_reg[i]   <= PW'(e1_reg[(i+1)%3]) * PW'(e2_reg[(i+2)%3]);
                q_reg[i]   <= PW'(e1_reg[(i+2)%3]) * PW'(e2_reg[(i+1)%3]);
                neg_reg[i] <= n_next[i][PW];
                mag_reg[i] <= n_next[i][PW] ? PW'(-n_next[i]) : PW'(n_next[i]);
            end
        end
    end

    assign ctrl_o = ctrl_reg;
    assign mag_o  = mag_reg;
    assign neg_o  = neg_reg;

endmodule

// ===== rtl/core/tfn_len.sv =====
module tfn_len #(
    parameter int MW = 2 * (tfn_pkg::COORD_WIDTH_DEF + 1),
    parameter int SW = 2 * MW,
    parameter int LW = SW + 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  tfn_pkg::ctrl_t  ctrl_i,
    input  logic [MW-1:0]   mag_i [3],
    input  logic            neg_i [3],
    output tfn_pkg::ctrl_t  ctrl_o,
    output logic [SW-1:0]   sq_o  [3],
    output logic [LW-1:0]   len2_o,
    output logic            neg_o [3]
);

    localparam int HB = MW / 2;
    localparam int TB = MW - HB;

    logic [2*TB-1:0]    hh_reg [3];
    logic [TB+HB-1:0]   hl_reg [3];
    logic [2*HB-1:0]    ll_reg [3];
    logic [SW-1:0]      sq_reg [3];
    logic [SW-1:0]      sq2_reg [3];
    logic [LW-1:0]      len2_reg;
    logic               n1_reg [3];
    logic               n2_reg [3];
    logic               n3_reg [3];
    tfn_pkg::ctrl_t     c1_reg, c2_reg, c3_reg;

    // control bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
        end else if (en) begin
            c1_reg <= ctrl_i;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
        end
    end

    // square of each magnitude from half-width partial products, then sum
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                hh_reg[i]  <= (2*TB)'(mag_i[i][MW-1:HB]) * (2*TB)'(mag_i[i][MW-1:HB]);
                hl_reg[i]  <= (TB+HB)'(mag_i[i][MW-1:HB]) * (TB+HB)'(mag_i[i][HB-1:0]);
                ll_reg[i]  <= (2*HB)'(mag_i[i][HB-1:0]) * (2*HB)'(mag_i[i][HB-1:0]);
                sq_reg[i]  <= (SW'(hh_reg[i]) << (2*HB)) + (SW'(hl_reg[i]) << (HB+1))
                              + SW'(ll_reg[i]);
                sq2_reg[i] <= sq_reg[i];
                n1_reg[i]  <= neg_i[i];
                n2_reg[i]  <= n1_reg[i];
                n3_reg[i]  <= n2_reg[i];
            end
            len2_reg <= LW'(sq_reg[0]) + LW'(sq_reg[1]) + LW'(sq_reg[2]);
        end
    end

    assign ctrl_o = c3_reg;
    assign sq_o   = sq2_reg;
    assign len2_o = len2_reg;
    assign neg_o  = n3_reg;

endmodule

// ===== rtl/core/tfn_unit.sv =====
module tfn_unit #(
    parameter int SW = 4 * (tfn_pkg::COORD_WIDTH_DEF + 1),
    parameter int LW = SW + 2,
    parameter int FB = tfn_pkg::NORMAL_FRAC_BITS_DEF,
    parameter int SB = FB + 2
) (
    input  logic            aclk,
    input  logic            en,
    input  logic [SW-1:0]   sq_i,
    input  logic [LW-1:0]   len2_i,
    input  logic            neg_i,
    output logic [SB-1:0]   root_o,
    output logic            neg_o
);

    // quotient floor(sq * 2^(2FB+2) / len2) has QB bits
    localparam int QB = 2 * FB + 3;
    localparam int RW = LW + 1;
    localparam int OW = 2 * SB;

    logic [RW-1:0] r_reg [QB];
    logic [QB-1:0] q_reg [QB];
    logic [LW-1:0] d_reg [QB];
    logic          nd_reg [QB];
    logic [OW-1:0] op_reg [SB];
    logic [OW-1:0] res_reg [SB];
    logic          ns_reg [SB];

    // restoring division, one quotient bit a stage
    for (genvar g = 0; g < QB; g++) begin : g_div
        logic [RW-1:0] r_in, r_diff;
        logic [QB-1:0] q_in;
        logic [LW-1:0] d_in;
        logic          n_in, take;
        if (g == 0) begin : g_first
            assign r_in = RW'(sq_i);
            assign q_in = '0;
            assign d_in = len2_i;
            assign n_in = neg_i;
        end else begin : g_rest
            assign r_in = {r_reg[g-1][RW-2:0], 1'b0};
            assign q_in = q_reg[g-1];
            assign d_in = d_reg[g-1];
            assign n_in = nd_reg[g-1];
        end
        assign take   = r_in >= RW'(d_in);
        assign r_diff = r_in - RW'(d_in);
        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[g]  <= take ? r_diff : r_in;
                q_reg[g]  <= q_in | (QB'(take) << (QB - 1 - g));
                d_reg[g]  <= d_in;
                nd_reg[g] <= n_in;
            end
        end
    end

    // digit-by-digit square root, one root bit a stage
    for (genvar h = 0; h < SB; h++) begin : g_sqrt
        localparam logic [OW-1:0] One = OW'(1) << (2 * (SB - 1 - h));
        logic [OW-1:0] op_in, res_in, trial;
        logic          n_in, ge;
        if (h == 0) begin : g_first
            assign op_in  = OW'(q_reg[QB-1]);
            assign res_in = '0;
            assign n_in   = nd_reg[QB-1];
        end else begin : g_rest
            assign op_in  = op_reg[h-1];
            assign res_in = res_reg[h-1];
            assign n_in   = ns_reg[h-1];
        end
        assign trial = res_in + One;
        assign ge    = op_in >= trial;
        always_ff @(posedge aclk) begin
            if (en) begin
                op_reg[h]  <= ge ? op_in - trial : op_in;
                res_reg[h] <= ge ? (res_in >> 1) + One : (res_in >> 1);
                ns_reg[h]  <= n_in;
            end
        end
    end

    assign root_o = res_reg[SB-1][SB-1:0];
    assign neg_o  = ns_reg[SB-1];

endmodule

// ===== tb/tb_triangle_face_normal_unit.sv =====
`timescale 1ns / 100ps

module tb_triangle_face_normal_unit;

    localparam int CW = tfn_pkg::COORD_WIDTH_DEF;
    localparam int FB = tfn_pkg::NORMAL_FRAC_BITS_DEF;
    localparam int NW = FB + 2;
    localparam int IW = ((9 * CW + 7) / 8) * 8;
    localparam int OW = ((3 * NW + 7) / 8) * 8;
    localparam int LATENCY = 3 * FB + 12;

    // nine coordinates in beat order: a_x a_y a_z b_x b_y b_z c_x c_y c_z
    typedef struct {
        logic signed [CW-1:0] crd[9];
    } triangle_t;

    typedef struct {
        logic signed [NW-1:0] nrm[3];
        logic                 degenerate;
    } normal_t;

    // expected unit normals, oldest first
    class normal_scoreboard;
        normal_t pending_q[$];
        int      errors;

        function new();
            errors = 0;
        endfunction

        // rounded magnitude of mag * 2^FB / sqrt(len2), ties away from zero
        function logic [127:0] unit_mag(logic [127:0] mag, logic [127:0] len2);
            logic [127:0] rhs, lhs, lo, hi, mid, m;
            rhs = (mag * mag) << (2 * FB + 2);
            lo  = 0;
            hi  = 128'd1 << FB;
            while (lo < hi) begin
                mid = lo + (hi - lo + 1) / 2;
                m   = 2 * mid - 1;
                lhs = m * m * len2;
                if (lhs <= rhs) lo = mid;
                else hi = mid - 1;
            end
            return lo;
        endfunction

        function void note_triangle(triangle_t t, bit flip);
            longint       a[3], b[3], c[3], e1[3], e2[3], n[3];
            logic [127:0] mag[3], len2, um;
            normal_t      want;
            for (int i = 0; i < 3; i++) begin
                a[i] = t.crd[i];
                b[i] = flip ? t.crd[6+i] : t.crd[3+i];
                c[i] = flip ? t.crd[3+i] : t.crd[6+i];
                e1[i] = b[i] - a[i];
                e2[i] = c[i] - a[i];
            end
            len2 = 0;
            for (int i = 0; i < 3; i++) begin
                n[i]   = e1[(i+1)%3] * e2[(i+2)%3] - e1[(i+2)%3] * e2[(i+1)%3];
                mag[i] = (n[i] < 0) ? -n[i] : n[i];
                len2   = len2 + mag[i] * mag[i];
            end
            want.degenerate = (len2 == 0);
            for (int i = 0; i < 3; i++) begin
                if (want.degenerate) begin
                    want.nrm[i] = '0;
                end else begin
                    um = unit_mag(mag[i], len2);
                    want.nrm[i] = (n[i] < 0) ? -um[NW-1:0] : um[NW-1:0];
                end
            end
            pending_q = {pending_q, want};
        endfunction

        function void check_normal(logic [OW-1:0] data, logic deg);
            normal_t want;
            logic signed [NW-1:0] got;
            if (pending_q.size() == 0) begin
                $error("unexpected normal beat: tdata %h tuser %b", data, deg);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            for (int i = 0; i < 3; i++) begin
                got = data[NW*i +: NW];
                if (got !== want.nrm[i]) begin
                    $error("normal_%s: expected %0d, actual %0d",
                           (i == 0) ? "x" : (i == 1) ? "y" : "z", want.nrm[i], got);
                    errors++;
                end
            end
            if (deg !== want.degenerate) begin
                $error("degenerate: expected %0b, actual %0b", want.degenerate, deg);
                errors++;
            end
        endfunction
    endclass

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [IW-1:0] s_tdata;    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    logic          m_tvalid;
    logic          m_tready;
    logic [OW-1:0] m_tdata;    // normal_x, normal_y, normal_z
    logic          m_tuser;    // degenerate
    logic          cfg_valid;
    logic          cfg_ready;
    logic          cfg_data;

    normal_scoreboard board = new();
    bit               flip_now;
    bit               no_idle;

    triangle_face_normal_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("tb_triangle_face_normal_unit NOT OK");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side back-pressure
    initial begin
        int n;
        m_tready = 1'b0;
        forever begin
            n = gap_len();
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_normal(m_tdata, m_tuser);
    end

    task automatic push_triangle(input triangle_t t);
        int g;
        logic [IW-1:0] d;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        d = '0;
        for (int i = 0; i < 9; i++) d[CW*i +: CW] = t.crd[i];
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        board.note_triangle(t, flip_now);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    task automatic write_winding(input bit v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        flip_now = v;
    endtask

    function automatic triangle_t tri_of(input int v[9]);
        triangle_t t;
        for (int i = 0; i < 9; i++) t.crd[i] = CW'(v[i]);
        return t;
    endfunction

    function automatic triangle_t rand_tri(input int kind);
        triangle_t t;
        int k, j, span;
        logic signed [CW-1:0] d[3];
        case (kind)
            0: begin
                for (int i = 0; i < 9; i++) t.crd[i] = CW'($urandom);
            end
            1: begin
                // small coordinates, many ties and near-axis normals
                span = $urandom_range(1, 8);
                for (int i = 0; i < 9; i++)
                    t.crd[i] = CW'($urandom_range(0, 2 * span) - span);
            end
            2: begin
                // collinear or coincident points
                for (int i = 0; i < 3; i++) begin
                    t.crd[i] = CW'($urandom_range(0, 2000) - 1000);
                    d[i]     = CW'($urandom_range(0, 200) - 100);
                end
                k = $urandom_range(0, 20) - 10;
                j = $urandom_range(0, 20) - 10;
                for (int i = 0; i < 3; i++) begin
                    t.crd[3+i] = CW'(t.crd[i] + k * d[i]);
                    t.crd[6+i] = CW'(t.crd[i] + j * d[i]);
                end
            end
            default: begin
                // extreme corners
                for (int i = 0; i < 9; i++)
                    t.crd[i] = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            end
        endcase
        return t;
    endfunction

    // directed triangles
    task automatic run_directed();
        push_triangle(tri_of('{0, 0, 0, 1, 0, 0, 0, 1, 0}));
        push_triangle(tri_of('{0, 0, 0, 0, 1, 0, 0, 0, 1}));
        push_triangle(tri_of('{0, 0, 0, 0, 0, 1, 1, 0, 0}));
        push_triangle(tri_of('{0, 0, 0, 1, 1, 0, -1, 1, 0}));
        push_triangle(tri_of('{5, 5, 5, 5, 5, 5, 5, 5, 5}));
        push_triangle(tri_of('{1, 2, 3, 2, 4, 6, 3, 6, 9}));
        push_triangle(tri_of('{-32768, -32768, -32768, -32768, -32768, -32768,
                                -32768, -32768, -32768}));
        push_triangle(tri_of('{-32768, -32768, -32768, 32767, -32768, -32768,
                                -32768, 32767, -32768}));
        push_triangle(tri_of('{32767, 32767, 32767, -32768, 32767, 32767,
                                32767, -32768, 32767}));
        push_triangle(tri_of('{-32768, 32767, -32768, 32767, -32768, 32767,
                                32767, 32767, -32768}));
        push_triangle(tri_of('{-32768, -32768, 0, 32767, -32768, 1, -32768, 32767, 0}));
        // tiny x and y next to a large z
        push_triangle(tri_of('{0, 0, 0, 32767, 0, 1, 0, 32767, 0}));
        push_triangle(tri_of('{0, 0, 0, 32767, -1, 0, 1, 32767, 0}));
        push_triangle(tri_of('{0, 0, 0, 2, 1, 0, 1, 2, 7}));
        push_triangle(tri_of('{-1, -1, -1, 1, 0, 0, 0, 1, 0}));
        push_triangle(tri_of('{32767, -32768, 32767, -32768, 32767, -32768,
                                0, 0, 1}));
        push_triangle(tri_of('{0, 0, 0, 3, 4, 0, 0, 0, 5}));
        push_triangle(tri_of('{-7, 3, 11, 2, -9, 4, 6, 8, -5}));
    endtask

    task automatic run_random(input int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            no_idle = ((i / 100) % 4 == 3);
            push_triangle(rand_tri((r < 55) ? 0 : (r < 75) ? 1 : (r < 93) ? 2 : 3));
            if (i == count / 2) drain();
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        flip_now  = 1'b0;
        no_idle   = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default winding, then flipped, then back again
        run_directed();
        run_random(600);
        drain();
        write_winding(1'b1);
        run_directed();
        run_random(600);
        drain();
        write_winding(1'b0);
        run_random(600);
        drain();

        if (board.pending_q.size() != 0) begin
            $error("%0d normals never arrived", board.pending_q.size());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("tb_triangle_face_normal_unit OK");
        end else begin
            $display("tb_triangle_face_normal_unit NOT OK");
        end
        $finish;
    end

endmodule
